[design/dar_pkg.sv]
package dar_pkg;

  // Angles are signed fixed point with six fraction bits (1/64 degree).
  localparam int ANGLE_W  = 15;
  localparam int REG_W    = 14;
  localparam int DIST_W   = 14;
  localparam int NUM_CELLS = 24;

  localparam logic signed [17:0] DEG180 = 18'sd11520;
  localparam logic signed [17:0] DEG360 = 18'sd23040;
  localparam logic signed [ANGLE_W-1:0] DIR_NONE = 15'sd11584;

  // Configuration register indexes.
  localparam logic [1:0] REG_ANGLE_A = 2'd0;
  localparam logic [1:0] REG_ANGLE_B = 2'd1;
  localparam logic [1:0] REG_THRESH  = 2'd2;

  typedef logic signed [ANGLE_W-1:0] ang_t;

  // Data carried from cell to cell: the six candidates and the running pick.
  typedef struct packed {
    logic                          valid;
    logic [5:0][ANGLE_W-1:0]       cand;
    logic                          have_min;
    logic [DIST_W-1:0]             min_d;
    logic                          found;
    logic [ANGLE_W-1:0]            dir;
  } stage_t;

  // Wrap a candidate once into the closed range from -180 to 180 degrees.
  function automatic ang_t wrap_once(input logic signed [17:0] t);
    logic signed [17:0] r;
    r = t;
    if (r > DEG180) r = r - DEG360;
    if (r < -DEG180) r = r + DEG360;
    return r[ANGLE_W-1:0];
  endfunction

  // Candidate indexes of the pair handled by cell n. Triples run with the
  // third index fastest; the pairs inside a triple are (a,b), (g,b), (g,a).
  function automatic int pair_p(input int n);
    int t;
    int r;
    t = n / 3;
    r = n % 3;
    if (r == 0) return ((t >> 2) & 1) * 3;
    return 2 + (t & 1) * 3;
  endfunction

  function automatic int pair_q(input int n);
    int t;
    int r;
    t = n / 3;
    r = n % 3;
    if (r == 2) return ((t >> 2) & 1) * 3;
    return 1 + ((t >> 1) & 1) * 3;
  endfunction

endpackage

[design/dar_front.sv]
module dar_front import dar_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [3*ANGLE_W-1:0] bearings,
  input  logic [REG_W-1:0]   angle_a,
  input  logic [REG_W-1:0]   angle_b,
  output stage_t             out
);

  logic signed [17:0] x [3];
  logic signed [17:0] mir [3];
  logic signed [17:0] off_a;
  logic signed [17:0] off_b;
  stage_t             nxt;

  // Mirror each bearing and rotate the second and third pair candidates.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x[i] = 18'(signed'(bearings[i*ANGLE_W +: ANGLE_W]));
      mir[i] = (x[i] >= 0) ? DEG180 - x[i] : -DEG180 - x[i];
    end
    off_a = DEG180 - 18'(signed'({1'b0, angle_a}));
    off_b = DEG180 - 18'(signed'({1'b0, angle_b}));
    nxt = '0;
    nxt.valid = in_valid;
    nxt.cand[0] = wrap_once(x[0]);
    nxt.cand[1] = wrap_once(x[1] - off_b);
    nxt.cand[2] = wrap_once(x[2] + off_a);
    nxt.cand[3] = wrap_once(mir[0]);
    nxt.cand[4] = wrap_once(mir[1] - off_b);
    nxt.cand[5] = wrap_once(mir[2] + off_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out <= '0;
    end else if (en) begin
      out <= nxt;
    end
  end

endmodule

[design/dar_cell.sv]
module dar_cell import dar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [REG_W-1:0] thresh,
  input  ang_t             p,
  input  ang_t             q,
  input  stage_t           in,
  output stage_t           out
);

  logic signed [15:0] diff;
  logic signed [15:0] sum;
  logic [15:0]        m;
  logic [15:0]        d;
  logic [15:0]        absd;
  logic [15:0]        abssum;
  logic [16:0]        hi_sum;
  logic               newmin;
  stage_t             nxt;

  // Compare this pair's circular distance with the best so far and update.
  always_comb begin
    diff = 16'(p) - 16'(q);
    sum  = 16'(p) + 16'(q);
    if (diff < 0) m = 16'(diff + 16'(DEG360));
    else if (diff == 16'(DEG360)) m = '0;
    else m = 16'(diff);
    d = (m > 16'(DEG180)) ? 16'(DEG360) - m : m;
    absd = (diff < 0) ? 16'(-diff) : 16'(diff);
    abssum = ((p < 0) ? 16'(-16'(p)) : 16'(p)) + ((q < 0) ? 16'(-16'(q)) : 16'(q));
    hi_sum = {1'b0, absd} + 17'(thresh);
    newmin = !in.have_min || (d[DIST_W-1:0] < in.min_d);
    nxt = in;
    if (newmin) begin
      nxt.have_min = 1'b1;
      nxt.min_d = d[DIST_W-1:0];
      if (absd <= 16'(thresh)) begin
        nxt.found = 1'b1;
        nxt.dir = sum[ANGLE_W:1];
      end
      if (hi_sum >= 17'(DEG360)) begin
        nxt.found = 1'b1;
        nxt.dir = abssum[ANGLE_W:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out <= '0;
    end else if (en) begin
      out <= nxt;
    end
  end

endmodule

[design/doa_ambiguity_resolver_core.sv]
// Resolves an arrival direction from three pair bearings (1/64 degree).
// One item is taken every cycle while the output is drained; the candidate
// stage registers each accepted item, then a chain of 24 cells, each testing
// one candidate pair, registers it in turn. A stall on the output holds the
// whole chain. direction is 181 degrees when found is low.
module doa_ambiguity_resolver_core import dar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // bearing_first, bearing_second, bearing_third, zeros
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // direction, zero
  output logic        m_tuser,   // found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  logic [REG_W-1:0] angle_a;
  logic [REG_W-1:0] angle_b;
  logic [REG_W-1:0] thresh;
  logic             en;
  stage_t           st [NUM_CELLS+1];

  assign cfg_ready = 1'b1;

  // Configuration registers take a transfer on any cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_a <= 14'd3840;
      angle_b <= 14'd3840;
      thresh  <= 14'd1280;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ANGLE_A: angle_a <= cfg_data;
        REG_ANGLE_B: angle_b <= cfg_data;
        REG_THRESH:  thresh  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The chain advances whenever the last stage is empty or being taken.
  assign en = !st[NUM_CELLS].valid || m_tready;
  assign s_tready = en;

  dar_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .bearings(s_tdata[3*ANGLE_W-1:0]), .angle_a(angle_a), .angle_b(angle_b),
    .out(st[0])
  );

  for (genvar n = 0; n < NUM_CELLS; n++) begin : g_cell
    dar_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .thresh(thresh),
      .p(st[n].cand[pair_p(n)]), .q(st[n].cand[pair_q(n)]),
      .in(st[n]), .out(st[n+1])
    );
  end

  // Output taken straight from the last cell's register.
  assign m_tvalid = st[NUM_CELLS].valid;
  assign m_tuser  = st[NUM_CELLS].found;
  assign m_tdata  = {1'b0, st[NUM_CELLS].found ? st[NUM_CELLS].dir : DIR_NONE};

endmodule

[verif/doa_ambiguity_resolver_core_tb.sv]
module doa_ambiguity_resolver_core_tb;
  import dar_pkg::*;

  localparam int FULL_TURN  = 23040;
  localparam int HALF_TURN  = 11520;
  localparam int DRAIN_WAIT = 40;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic signed [14:0] first;
    logic signed [14:0] second;
    logic signed [14:0] third;
  } bearing_set_t;

  typedef struct packed {
    logic signed [14:0] direction;
    logic               found;
  } resolution_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;

  doa_ambiguity_resolver_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration.
  int geom_a = 3840;
  int geom_b = 3840;
  int match_thr = 1280;

  bearing_set_t pending_sets[$];
  resolution_t  expected_dirs[$];
  int  errors = 0;
  int  results_seen = 0;
  int  found_seen = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1;
  bit  s_acc = 0;
  bit  m_acc = 0;
  int  send_gap = 0;
  int  recv_stall = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int arc_distance(int p, int q);
    int m;
    m = (p - q) % FULL_TURN;
    if (m < 0) m += FULL_TURN;
    if (m > FULL_TURN - m) m = FULL_TURN - m;
    return m;
  endfunction

  function automatic int wrap_angle(int t);
    if (t > HALF_TURN) t -= FULL_TURN;
    if (t < -HALF_TURN) t += FULL_TURN;
    return t;
  endfunction

  function automatic int abs_int(int v);
    return v < 0 ? -v : v;
  endfunction

  // Predicts the resolved direction of one bearing set.
  function automatic resolution_t resolve_direction(bearing_set_t bs);
    int c[6];
    int p, q, d, diff, best, dir;
    bit have, hit;
    resolution_t r;
    c[0] = bs.first;
    c[1] = bs.second;
    c[2] = bs.third;
    for (int i = 0; i < 3; i++) begin
      c[i + 3] = (c[i] >= 0) ? HALF_TURN - c[i] : -HALF_TURN - c[i];
    end
    c[1] -= HALF_TURN - geom_b;
    c[4] -= HALF_TURN - geom_b;
    c[2] += HALF_TURN - geom_a;
    c[5] += HALF_TURN - geom_a;
    for (int i = 0; i < 6; i++) c[i] = wrap_angle(c[i]);
    have = 0;
    best = 0;
    hit = 0;
    dir = 0;
    for (int t = 0; t < 8; t++) begin
      for (int n = 0; n < 3; n++) begin
        // Pairs within a triple: (first,second), (third,second), (third,first).
        if (n == 0) begin
          p = c[((t >> 2) & 1) * 3];
          q = c[1 + ((t >> 1) & 1) * 3];
        end else if (n == 1) begin
          p = c[2 + (t & 1) * 3];
          q = c[1 + ((t >> 1) & 1) * 3];
        end else begin
          p = c[2 + (t & 1) * 3];
          q = c[((t >> 2) & 1) * 3];
        end
        d = arc_distance(p, q);
        if (!have || d < best) begin
          have = 1;
          best = d;
          diff = abs_int(p - q);
          if (diff <= match_thr) begin
            hit = 1;
            dir = (p + q) >>> 1;
          end
          if (diff >= FULL_TURN - match_thr) begin
            hit = 1;
            dir = (abs_int(p) + abs_int(q)) >>> 1;
          end
        end
      end
    end
    if (!hit) dir = DIR_NONE;
    r.direction = dir[14:0];
    r.found = hit;
    return r;
  endfunction

  // Input side: record each transfer and its expected result.
  always @(posedge clk) begin
    s_acc <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_dirs.push_back(resolve_direction(
        bearing_set_t'({s_tdata[14:0], s_tdata[29:15], s_tdata[44:30]})));
    end
  end

  // Driver: presents queued bearing sets with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_acc)) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_sets.size() > 0) begin
        bearing_set_t bs;
        bs = pending_sets.pop_front();
        s_tdata <= {3'b000, bs.third, bs.second, bs.first};
        s_tvalid <= 1'b1;
        send_gap <= gaps_on ? $urandom_range(0, 12) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: when gaps are on, stalls for a random time after each result transfer.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_acc) begin
      int hold;
      hold = gaps_on ? $urandom_range(0, 12) : 0;
      recv_stall <= (hold > 0) ? hold - 1 : 0;
      m_tready <= (hold == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    m_acc <= m_tvalid && m_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_dirs.size() == 0) begin
        $error("result transfer with nothing expected: direction %0d found %0d",
               $signed(m_tdata[14:0]), m_tuser);
        errors++;
      end else begin
        resolution_t e;
        e = expected_dirs.pop_front();
        if (m_tdata[14:0] !== e.direction) begin
          $error("direction: expected %0d, actual %0d", e.direction,
                 $signed(m_tdata[14:0]));
          errors++;
        end
        if (m_tuser !== e.found) begin
          $error("found: expected %0d, actual %0d", e.found, m_tuser);
          errors++;
        end
        results_seen++;
        if (e.found) found_seen++;
      end
    end
  end

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value[13:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ANGLE_A) geom_a = value;
    else if (idx == REG_ANGLE_B) geom_b = value;
    else match_thr = value;
  endtask

  task automatic add_set(int f, int s, int t);
    bearing_set_t bs;
    bs.first = f[14:0];
    bs.second = s[14:0];
    bs.third = t[14:0];
    pending_sets.push_back(bs);
  endtask

  function automatic int rand_bearing();
    return $urandom_range(0, 2 * HALF_TURN) - HALF_TURN;
  endfunction

  function automatic int clamp_bearing(int v);
    if (v > HALF_TURN) return HALF_TURN;
    if (v < -HALF_TURN) return -HALF_TURN;
    return v;
  endfunction

  task automatic add_random(int count);
    int f;
    for (int i = 0; i < count; i++) begin
      f = rand_bearing();
      case ($urandom_range(0, 3))
        0: add_set(rand_bearing(), rand_bearing(), rand_bearing());
        // Nearly agreeing bearings, so that the threshold test decides.
        1: add_set(f, clamp_bearing(f + $urandom_range(0, 1600) - 800),
                   clamp_bearing(f + $urandom_range(0, 1600) - 800));
        // Bearings offset by the geometry angles, close to a true source.
        2: add_set(f, clamp_bearing(f - HALF_TURN + geom_b + $urandom_range(0, 400) - 200),
                   clamp_bearing(f + HALF_TURN - geom_a + $urandom_range(0, 400) - 200));
        default: add_set(f, -f, clamp_bearing(HALF_TURN - f));
      endcase
    end
  endtask

  task automatic drain();
    while (pending_sets.size() > 0 || s_tvalid || expected_dirs.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ANGLE_A;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed sets under the reset configuration.
    add_set(0, 0, 0);
    add_set(HALF_TURN, HALF_TURN, HALF_TURN);
    add_set(-HALF_TURN, -HALF_TURN, -HALF_TURN);
    add_set(HALF_TURN, -HALF_TURN, 0);
    add_set(-1, 1, -1);
    add_set(3840, -3840, 3840);
    add_set(1000, 1000 - 7680, 1000 + 7680);
    add_set(11000, -11000, 11400);
    add_set(-11500, 11500, -11300);
    add_set(1280, 0, -1280);
    add_set(1281, 0, 5000);
    add_set(5760, 5760, 5760);
    add_set(-5760, 100, 9000);
    add_set(16'sh0555, 16'sh2AAA, -16'sh2AAA);
    add_set(7000, -7000, 2000);
    add_set(-1, -1, -1);
    add_random(60);
    drain();

    // Configuration sweep including the extremes.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(REG_ANGLE_A, 0); write_reg(REG_ANGLE_B, 0);
                 write_reg(REG_THRESH, 0); end
        1: begin write_reg(REG_ANGLE_A, HALF_TURN); write_reg(REG_ANGLE_B, HALF_TURN);
                 write_reg(REG_THRESH, HALF_TURN); end
        2: begin write_reg(REG_ANGLE_A, 0); write_reg(REG_ANGLE_B, HALF_TURN);
                 write_reg(REG_THRESH, 16383 & HALF_TURN); end
        3: begin write_reg(REG_ANGLE_A, 3840); write_reg(REG_ANGLE_B, 3840);
                 write_reg(REG_THRESH, 1280); end
        default: begin
          write_reg(REG_ANGLE_A, $urandom_range(0, HALF_TURN));
          write_reg(REG_ANGLE_B, $urandom_range(0, HALF_TURN));
          write_reg(REG_THRESH, $urandom_range(0, 3000));
        end
      endcase
      gaps_on = (ph != 3);
      add_random(70);
      drain();
    end

    $display("Checked %0d resolved directions, %0d of them found, over 8 settings.",
             results_seen, found_seen);
    $display("Settings covered zero and full-scale geometry angles and thresholds.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
